/* rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and control types of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH         = 16;
	localparam int PRIORITY_BITS = 8;
	localparam int PAYLOAD_BITS  = 16;
	localparam int COUNT_BITS    = $clog2(DEPTH + 1);

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_POP    = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef logic [PRIORITY_BITS-1:0] prio_t;
	typedef logic [PAYLOAD_BITS-1:0]  pay_t;
	typedef logic [COUNT_BITS-1:0]    count_t;

	typedef struct packed {
		logic       load;
		logic       do_insert;
		logic       do_pop;
		logic [1:0] status;
	} spq_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} spq_stat_t;

endpackage

/* rtl/spq_req_if.sv */
// ----------------------------------------------------------------------------
// spq_req_if / spq_rsp_if
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
interface spq_req_if;
	logic                           valid;
	logic                           ready;
	logic                           command;
	logic [spq_pkg::PRIORITY_BITS-1:0] priority_req;
	logic [spq_pkg::PAYLOAD_BITS-1:0]  payload;

	modport source (output valid, command, priority_req, payload, input ready);
	modport sink   (input valid, command, priority_req, payload, output ready);
endinterface

interface spq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        status;
	logic [spq_pkg::PRIORITY_BITS-1:0] out_priority;
	logic [spq_pkg::PAYLOAD_BITS-1:0]  out_payload;
	logic [spq_pkg::COUNT_BITS-1:0]    occupancy;

	modport source (output valid, status, out_priority, out_payload, occupancy,
		input ready);
	modport sink   (input valid, status, out_priority, out_payload, occupancy,
		output ready);
endinterface

/* rtl/stable_priority_queue.sv */
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded sorted priority queue; equal priorities leave in arrival order.
//
//   port  dir   word fields
//   req   sink  command, priority_req, payload
//   rsp   src   status, out_priority, out_payload, occupancy
//
// One command word per cycle while results are drained; its result word appears the cycle after accept.
// All slots compare and shift in parallel, so cost is flat in
// occupancy. req.ready stays high while the result register is empty or being
// drained in the same cycle. Reset clears the count and the handshake state only;
// slot contents are unknown until written and never read before then.
// ----------------------------------------------------------------------------
module stable_priority_queue (
	input logic      clk,
	input logic      arst_n,
	spq_req_if.sink  req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	spq_ctl_t  ctl;
	spq_stat_t stat;

	spq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_ready   (req.ready),
		.in_command (req.command),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.stat       (stat),
		.ctl        (ctl)
	);

	spq_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.req_prio   (req.priority_req),
		.req_pay    (req.payload),
		.res_status (rsp.status),
		.res_prio   (rsp.out_priority),
		.res_pay    (rsp.out_payload),
		.res_count  (rsp.occupancy)
	);
endmodule

/* rtl/spq_ctrl.sv */
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: accepts a command word while the result register is
// free or being drained, and decides the operation and its status code.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_command,
	output logic               out_valid,
	input  logic               out_ready,
	input  spq_pkg::spq_stat_t stat,
	output spq_pkg::spq_ctl_t  ctl
);
	import spq_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_HOLD = 1'b1;

	logic state_q;
	logic state_d;

	assign in_ready  = (state_q == S_IDLE) || out_ready;
	assign out_valid = (state_q == S_HOLD);

	always_comb begin
		ctl.load      = in_valid && in_ready;
		ctl.do_insert = ctl.load && (in_command == CMD_INSERT) && !stat.full;
		ctl.do_pop    = ctl.load && (in_command == CMD_POP) && !stat.empty;
		if ((in_command == CMD_POP) && stat.empty) begin
			ctl.status = ST_EMPTY;
		end else if ((in_command == CMD_INSERT) && stat.full) begin
			ctl.status = ST_FULL;
		end else begin
			ctl.status = ST_OK;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (ctl.load) state_d = S_HOLD;
			end
			S_HOLD: begin
				if (out_ready && !ctl.load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_load_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> out_valid) else $error("accepted command without result");
	a_held_word_stays: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result word lost");
	a_no_op_when_bad: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.status != ST_OK |-> !ctl.do_insert && !ctl.do_pop)
		else $error("queue updated on failed command");
endmodule

/* rtl/spq_datapath.sv */
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted slot cells with parallel compare, shift-in on insert, shift-up on
// pop, entry count and result register.
// ----------------------------------------------------------------------------
module spq_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::spq_ctl_t  ctl,
	output spq_pkg::spq_stat_t stat,
	input  spq_pkg::prio_t     req_prio,
	input  spq_pkg::pay_t      req_pay,
	output logic [1:0]         res_status,
	output spq_pkg::prio_t     res_prio,
	output spq_pkg::pay_t      res_pay,
	output spq_pkg::count_t    res_count
);
	import spq_pkg::*;

	prio_t  slot_prio_q [DEPTH];
	pay_t   slot_pay_q  [DEPTH];
	count_t count_q;
	logic   [DEPTH-1:0] ge;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == COUNT_BITS'(DEPTH));

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			prio_t nxt_prio;
			pay_t  nxt_pay;
			logic  prev_ge;
			prio_t up_prio;
			pay_t  up_pay;
			prio_t dn_prio;
			pay_t  dn_pay;

			assign ge[g] = (COUNT_BITS'(g) < count_q) && (slot_prio_q[g] >= req_prio);

			if (g == 0) begin : g_first
				assign prev_ge = 1'b1;
				assign dn_prio = slot_prio_q[g];
				assign dn_pay  = slot_pay_q[g];
			end else begin : g_rest
				assign prev_ge = ge[g-1];
				assign dn_prio = slot_prio_q[g-1];
				assign dn_pay  = slot_pay_q[g-1];
			end

			if (g == DEPTH - 1) begin : g_last
				assign up_prio = slot_prio_q[g];
				assign up_pay  = slot_pay_q[g];
			end else begin : g_mid
				assign up_prio = slot_prio_q[g+1];
				assign up_pay  = slot_pay_q[g+1];
			end

			always_comb begin
				if (ctl.do_pop) begin
					nxt_prio = up_prio;
					nxt_pay  = up_pay;
				end else if (ge[g]) begin
					nxt_prio = slot_prio_q[g];
					nxt_pay  = slot_pay_q[g];
				end else if (prev_ge) begin
					nxt_prio = req_prio;
					nxt_pay  = req_pay;
				end else begin
					nxt_prio = dn_prio;
					nxt_pay  = dn_pay;
				end
			end

			always_ff @(posedge clk) begin
				if (ctl.do_insert || ctl.do_pop) begin
					slot_prio_q[g] <= nxt_prio;
					slot_pay_q[g]  <= nxt_pay;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.do_insert) begin
			count_q <= count_q + COUNT_BITS'(1);
		end else if (ctl.do_pop) begin
			count_q <= count_q - COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			res_status <= ctl.status;
			res_prio   <= ctl.do_pop ? slot_prio_q[0] : '0;
			res_pay    <= ctl.do_pop ? slot_pay_q[0] : '0;
			if (ctl.do_insert) begin
				res_count <= count_q + COUNT_BITS'(1);
			end else if (ctl.do_pop) begin
				res_count <= count_q - COUNT_BITS'(1);
			end else begin
				res_count <= count_q;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_BITS'(DEPTH)) else $error("entry count overflow");
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= COUNT_BITS'(2) |-> slot_prio_q[0] >= slot_prio_q[1])
		else $error("head out of order");
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.do_insert |=> count_q == $past(count_q) + COUNT_BITS'(1))
		else $error("insert did not grow queue");
endmodule
